// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the lock RTL.
// Depends on nothing; the including module must provide clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TPKL_ASSERT_SAME(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TPKL_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- rtl/core/tpkl_pkg.sv -----
// Types and constants of the two-phase keypad lock.
// Used by tpkl_step and two_phase_keypad_lock_unit; depends on nothing.
package tpkl_pkg;

  localparam int CfgIndexW = 3;
  localparam int CfgDataW  = 20;

  localparam logic [1:0] REQ_KEY  = 2'd0;
  localparam logic [1:0] REQ_TICK = 2'd1;
  localparam logic [1:0] REQ_CODE = 2'd2;

  localparam logic [3:0] KEY_ONE  = 4'd1;
  localparam logic [3:0] KEY_TWO  = 4'd2;
  localparam logic [3:0] KEY_D    = 4'd13;
  localparam logic [3:0] KEY_STAR = 4'd14;
  localparam logic [3:0] KEY_HASH = 4'd15;
  localparam logic [3:0] DIGIT_MAX = 4'd9;

  localparam logic [2:0] MODE_SEL   = 3'd0;
  localparam logic [2:0] MODE_P1    = 3'd1;
  localparam logic [2:0] MODE_P2    = 3'd2;
  localparam logic [2:0] MODE_OPEN  = 3'd3;
  localparam logic [2:0] MODE_ALARM = 3'd4;

  localparam logic [1:0] LOCKER_NONE = 2'd0;
  localparam logic [1:0] LOCKER_ONE  = 2'd1;
  localparam logic [1:0] LOCKER_TWO  = 2'd2;

  localparam logic [3:0] EV_NONE    = 4'd0;
  localparam logic [3:0] EV_PASS    = 4'd1;
  localparam logic [3:0] EV_WRONG   = 4'd2;
  localparam logic [3:0] EV_ALARM   = 4'd3;
  localparam logic [3:0] EV_OPENED  = 4'd4;
  localparam logic [3:0] EV_AUTO    = 4'd5;
  localparam logic [3:0] EV_MANUAL  = 4'd6;
  localparam logic [3:0] EV_RESET   = 4'd7;
  localparam logic [3:0] EV_CLEARED = 4'd8;

  localparam logic [CfgIndexW-1:0] REG_SHARED_PIN   = 3'd0;
  localparam logic [CfgIndexW-1:0] REG_PIN_ONE      = 3'd1;
  localparam logic [CfgIndexW-1:0] REG_PIN_TWO      = 3'd2;
  localparam logic [CfgIndexW-1:0] REG_MAX_FAILS    = 3'd3;
  localparam logic [CfgIndexW-1:0] REG_UNLOCK_TICKS = 3'd4;
  localparam logic [CfgIndexW-1:0] REG_ALARM_TICKS  = 3'd5;

  localparam logic [15:0] RST_SHARED_PIN   = 16'h1234;
  localparam logic [15:0] RST_PIN_ONE      = 16'h5678;
  localparam logic [15:0] RST_PIN_TWO      = 16'h9012;
  localparam logic [2:0]  RST_MAX_FAILS    = 3'd3;
  localparam logic [19:0] RST_UNLOCK_TICKS = 20'd300000;
  localparam logic [19:0] RST_ALARM_TICKS  = 20'd10000;

  localparam int LAMP_OPEN_ONE = 0;
  localparam int LAMP_OPEN_TWO = 1;
  localparam int LAMP_RED_ONE  = 2;
  localparam int LAMP_RED_TWO  = 3;
  localparam int LAMP_BUZZER   = 4;

  typedef struct packed {
    logic [1:0] req_type;
    logic [3:0] key_code;
    logic [6:0] otp_one;
    logic [6:0] otp_two;
  } req_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [1:0] active_locker;
    logic       open_one;
    logic       open_two;
    logic       red_one;
    logic       red_two;
    logic       buzzer_on;
    logic [2:0] keys_entered;
    logic [2:0] fail_count;
    logic [3:0] event_res;
  } rsp_t;

  typedef struct packed {
    logic [15:0] shared_pin;
    logic [15:0] pin_one;
    logic [15:0] pin_two;
    logic [2:0]  max_fails;
    logic [19:0] unlock_ticks;
    logic [19:0] alarm_ticks;
  } cfg_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [1:0] locker;
    logic [2:0] fails;
    logic [2:0] entry_len;
    logic [6:0] code_one;
    logic [6:0] code_two;
    logic       code_valid;
    logic [4:0] lamps;
  } state_t;

  typedef logic [5:0][3:0] keys_t;

endpackage

// ----- rtl/core/tpkl_step.sv -----
// Next-state logic of the keypad lock for one request beat.
// Depends on tpkl_pkg for the request, result, state and register types.
module tpkl_step #(
  parameter int TIMER_WIDTH = 20
) (
  input  tpkl_pkg::cfg_t           cfg,
  input  tpkl_pkg::req_t           item,
  input  tpkl_pkg::state_t         state,
  input  logic [TIMER_WIDTH-1:0]   elapsed,
  input  tpkl_pkg::keys_t          keys,
  output tpkl_pkg::state_t         state_next,
  output logic [TIMER_WIDTH-1:0]   elapsed_next,
  output tpkl_pkg::keys_t          keys_next,
  output tpkl_pkg::rsp_t           result
);
  import tpkl_pkg::*;

  localparam int CmpW = (TIMER_WIDTH > CfgDataW) ? TIMER_WIDTH : CfgDataW;

  function automatic logic [3:0] tens_of(input logic [6:0] v);
    logic [3:0] t;
    t = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (v >= 7'(10 * k)) begin
        t = t + 4'd1;
      end
    end
    return t;
  endfunction

  logic [2:0]             fails_inc;
  logic                   alarm_hit;
  logic [4:0]             red_bits;
  logic [4:0]             open_bits;
  logic [4:0]             wrong_lamps;
  logic [4:0]             closed_lamps;
  logic [TIMER_WIDTH-1:0] elapsed_inc;
  logic                   unlock_hit;
  logic                   alarm_done;
  logic [2:0]             entry_cap;
  logic                   entry_wr;
  logic [2:0]             len_w;
  keys_t                  keys_w;
  logic [15:0]            pin_sel;
  logic [6:0]             code_sel;
  logic [3:0]             code_tens;
  logic [3:0]             code_ones;
  logic [5:0][3:0]        want;
  logic [5:0]             digit_ok;
  logic                   p1_match;
  logic                   p2_match;
  logic [3:0]             event_code;

  assign fails_inc = (state.fails == 3'd7) ? state.fails : state.fails + 3'd1;
  assign alarm_hit = fails_inc >= cfg.max_fails;

  always_comb begin
    red_bits  = '0;
    open_bits = '0;
    if (state.locker == LOCKER_ONE) begin
      red_bits[LAMP_RED_ONE]   = 1'b1;
      open_bits[LAMP_OPEN_ONE] = 1'b1;
    end else if (state.locker == LOCKER_TWO) begin
      red_bits[LAMP_RED_TWO]   = 1'b1;
      open_bits[LAMP_OPEN_TWO] = 1'b1;
    end
  end

  assign wrong_lamps  = state.lamps | red_bits | (5'd1 << LAMP_BUZZER);
  assign closed_lamps = state.lamps & ~open_bits;

  assign elapsed_inc = (elapsed == '1) ? elapsed : elapsed + TIMER_WIDTH'(1);
  assign unlock_hit  = CmpW'(elapsed_inc) >= CmpW'(cfg.unlock_ticks);
  assign alarm_done  = CmpW'(elapsed_inc) >= CmpW'(cfg.alarm_ticks);

  assign entry_cap = (state.mode == MODE_P2) ? 3'd6 : 3'd4;
  assign entry_wr  = state.entry_len < entry_cap;
  assign len_w     = entry_wr ? state.entry_len + 3'd1 : state.entry_len;

  always_comb begin
    keys_w = keys;
    if (entry_wr) begin
      keys_w[state.entry_len] = item.key_code;
    end
  end

  assign pin_sel   = (state.locker == LOCKER_TWO) ? cfg.pin_two : cfg.pin_one;
  assign code_sel  = (state.locker == LOCKER_TWO) ? state.code_two : state.code_one;
  assign code_tens = tens_of(code_sel);
  assign code_ones = 4'(code_sel - 7'(code_tens) * 7'd10);

  always_comb begin
    want[0] = (state.mode == MODE_P2) ? pin_sel[15:12] : cfg.shared_pin[15:12];
    want[1] = (state.mode == MODE_P2) ? pin_sel[11:8]  : cfg.shared_pin[11:8];
    want[2] = (state.mode == MODE_P2) ? pin_sel[7:4]   : cfg.shared_pin[7:4];
    want[3] = (state.mode == MODE_P2) ? pin_sel[3:0]   : cfg.shared_pin[3:0];
    want[4] = code_tens;
    want[5] = code_ones;
    for (int i = 0; i < 6; i++) begin
      digit_ok[i] = (keys_w[i] <= DIGIT_MAX) && (keys_w[i] == want[i]);
    end
  end

  assign p1_match = &digit_ok[3:0];
  assign p2_match = (&digit_ok) && state.code_valid && (code_sel <= 7'd99)
                    && (state.locker == LOCKER_ONE || state.locker == LOCKER_TWO);

  always_comb begin
    state_next   = state;
    elapsed_next = elapsed;
    keys_next    = keys;
    event_code   = EV_NONE;
    case (item.req_type)
      REQ_KEY: begin
        if (item.key_code == KEY_HASH) begin
          state_next.mode      = MODE_SEL;
          state_next.locker    = LOCKER_NONE;
          state_next.fails     = 3'd0;
          state_next.entry_len = 3'd0;
          state_next.lamps     = '0;
          elapsed_next         = '0;
          event_code           = EV_RESET;
        end else if (item.key_code == KEY_D && state.mode == MODE_OPEN) begin
          state_next.lamps = closed_lamps;
          state_next.mode  = MODE_SEL;
          event_code       = EV_MANUAL;
        end else if (item.key_code == KEY_STAR) begin
          if ((state.mode == MODE_P1 || state.mode == MODE_P2) && state.entry_len != 3'd0) begin
            state_next.entry_len = state.entry_len - 3'd1;
          end
        end else begin
          case (state.mode)
            MODE_SEL: begin
              if (item.key_code inside {KEY_ONE, KEY_TWO}) begin
                state_next.locker    = item.key_code[1:0];
                state_next.fails     = 3'd0;
                state_next.entry_len = 3'd0;
                state_next.mode      = MODE_P1;
              end
            end
            MODE_P1, MODE_P2: begin
              keys_next            = keys_w;
              state_next.entry_len = len_w;
              if (len_w >= entry_cap) begin
                if (state.mode == MODE_P1 && p1_match) begin
                  state_next.fails     = 3'd0;
                  state_next.entry_len = 3'd0;
                  state_next.mode      = MODE_P2;
                  event_code           = EV_PASS;
                end else if (state.mode == MODE_P2 && p2_match) begin
                  state_next.lamps     = (state.lamps | open_bits) & ~red_bits;
                  state_next.mode      = MODE_OPEN;
                  state_next.entry_len = 3'd0;
                  elapsed_next         = '0;
                  event_code           = EV_OPENED;
                end else begin
                  state_next.fails     = fails_inc;
                  state_next.entry_len = 3'd0;
                  if (alarm_hit) begin
                    state_next.mode  = MODE_ALARM;
                    state_next.lamps = wrong_lamps;
                    elapsed_next     = '0;
                    event_code       = EV_ALARM;
                  end else begin
                    event_code = EV_WRONG;
                  end
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      REQ_TICK: begin
        if (state.mode == MODE_OPEN || state.mode == MODE_ALARM) begin
          elapsed_next = elapsed_inc;
          if (state.mode == MODE_OPEN && unlock_hit) begin
            state_next.lamps = closed_lamps;
            state_next.mode  = MODE_SEL;
            event_code       = EV_AUTO;
          end else if (state.mode == MODE_ALARM && alarm_done) begin
            state_next.mode      = MODE_SEL;
            state_next.locker    = LOCKER_NONE;
            state_next.fails     = 3'd0;
            state_next.entry_len = 3'd0;
            state_next.lamps     = '0;
            elapsed_next         = '0;
            event_code           = EV_RESET;
          end
        end
      end
      REQ_CODE: begin
        state_next.code_one   = item.otp_one;
        state_next.code_two   = item.otp_two;
        state_next.code_valid = 1'b1;
        if (state.mode == MODE_P2) begin
          state_next.entry_len = 3'd0;
          event_code           = EV_CLEARED;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result.mode          = state_next.mode;
    result.active_locker = state_next.locker;
    result.open_one      = state_next.lamps[LAMP_OPEN_ONE];
    result.open_two      = state_next.lamps[LAMP_OPEN_TWO];
    result.red_one       = state_next.lamps[LAMP_RED_ONE];
    result.red_two       = state_next.lamps[LAMP_RED_TWO];
    result.buzzer_on     = state_next.lamps[LAMP_BUZZER];
    result.keys_entered  = state_next.entry_len;
    result.fail_count    = state_next.fails;
    result.event_res     = event_code;
  end

endmodule

// ----- rtl/core/two_phase_keypad_lock_unit.sv -----
// Top level of the two-phase keypad lock: beat registers, lock state and config.
// Depends on tpkl_pkg, tpkl_step and assert_macros.svh.
//
// Usage:
// A request beat (key press, tick or new one-time codes) enters on req_valid and
// req_data and is taken at an edge where req_valid is high and req_stall is low.
// Every request gives exactly one result beat on rsp_valid and rsp_data, which the
// receiver takes at an edge where rsp_stall is low.
// A request is first held in an input register; from there the lock logic updates the
// state and loads the result register once the result register is empty or taken.
// One request is taken per cycle, sustained, while the receiver does not stall.
// That rate is set by the combinational state update in tpkl_step.
// When the receiver stalls, the result register holds its beat and the input
// register holds one more request, after which req_stall rises.
// Registers are written on cfg_valid with cfg_index and cfg_data; cfg_ready is
// always high. The user, not the block, must make writes only while no request is in flight.
// Synchronous reset returns the lock to select mode with all lamps off, clears the
// stored codes and loads the default PINs and limits. There is no clearing pass.
`include "assert_macros.svh"

module two_phase_keypad_lock_unit #(
  parameter int TIMER_WIDTH = 20
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  tpkl_pkg::req_t                    req_data,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output tpkl_pkg::rsp_t                    rsp_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tpkl_pkg::CfgIndexW-1:0]    cfg_index,
  input  logic [tpkl_pkg::CfgDataW-1:0]     cfg_data
);
  import tpkl_pkg::*;

  cfg_t                   regs;
  req_t                   item;
  logic                   item_valid;
  state_t                 state;
  state_t                 state_next;
  logic [TIMER_WIDTH-1:0] elapsed;
  logic [TIMER_WIDTH-1:0] elapsed_next;
  keys_t                  keys;
  keys_t                  keys_next;
  rsp_t                   result;
  logic                   advance;

  assign cfg_ready = 1'b1;
  assign advance   = item_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = item_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.shared_pin   <= RST_SHARED_PIN;
      regs.pin_one      <= RST_PIN_ONE;
      regs.pin_two      <= RST_PIN_TWO;
      regs.max_fails    <= RST_MAX_FAILS;
      regs.unlock_ticks <= RST_UNLOCK_TICKS;
      regs.alarm_ticks  <= RST_ALARM_TICKS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SHARED_PIN:   regs.shared_pin   <= cfg_data[15:0];
        REG_PIN_ONE:      regs.pin_one      <= cfg_data[15:0];
        REG_PIN_TWO:      regs.pin_two      <= cfg_data[15:0];
        REG_MAX_FAILS:    regs.max_fails    <= cfg_data[2:0];
        REG_UNLOCK_TICKS: regs.unlock_ticks <= cfg_data;
        REG_ALARM_TICKS:  regs.alarm_ticks  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!req_stall) begin
      item_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      item <= req_data;
    end
  end

  tpkl_step #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_step (
    .cfg          (regs),
    .item         (item),
    .state        (state),
    .elapsed      (elapsed),
    .keys         (keys),
    .state_next   (state_next),
    .elapsed_next (elapsed_next),
    .keys_next    (keys_next),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode       <= MODE_SEL;
      state.locker     <= LOCKER_NONE;
      state.fails      <= 3'd0;
      state.entry_len  <= 3'd0;
      state.code_one   <= 7'd0;
      state.code_two   <= 7'd0;
      state.code_valid <= 1'b0;
      state.lamps      <= '0;
      elapsed          <= '0;
    end else if (advance) begin
      state   <= state_next;
      elapsed <= elapsed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      keys     <= keys_next;
      rsp_data <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  `TPKL_ASSERT_NEXT(a_advance_gives_beat, advance, rsp_valid, "Taken request gave no result beat.")
  `TPKL_ASSERT_SAME(a_bolt_only_open, state.lamps[1:0] != 2'b00, state.mode == MODE_OPEN, "Bolt open outside unlocked mode.")
  `TPKL_ASSERT_SAME(a_buzzer_alarm, 1'b1, state.lamps[LAMP_BUZZER] == (state.mode == MODE_ALARM), "Buzzer does not follow alarm mode.")
  `TPKL_ASSERT_SAME(a_entry_idle_empty, state.mode != MODE_P1 && state.mode != MODE_P2, state.entry_len == 3'd0, "Entry buffer not empty outside entry phases.")

endmodule
